// ===== rtl/pnm_pkg.sv =====
// Shared types and codes for the raw PNM stream decoder.
`timescale 1ns / 1ps
package pnm_pkg;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    // Image formats as reported on the result port.
    localparam logic [1:0] FMT_PBM = 2'd0;
    localparam logic [1:0] FMT_PGM = 2'd1;
    localparam logic [1:0] FMT_PPM = 2'd2;

    // Error codes; pixel and header results carry ERR_NONE.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_P     = 3'd0;
    localparam logic [2:0] ERR_BAD_TYPE = 3'd1;
    localparam logic [2:0] ERR_MAXVAL   = 3'd2;
    localparam logic [2:0] ERR_NO_WS    = 3'd3;
    localparam logic [2:0] ERR_BAD_NUM  = 3'd4;
    localparam logic [2:0] ERR_TRUNC    = 3'd5;

    // One queued work entry: produces cnt_m1+1 results in the back end.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [1:0] fmt;
        logic [2:0] err;
        logic [2:0] cnt_m1;
        logic       pbm;
        logic       frame;
    } t_cmd;

endpackage

// ===== rtl/pnm_front.sv =====
// Header parser and raster classifier: turns each byte into at most one work entry.
`timescale 1ns / 1ps
module pnm_front #(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_byte_in,
    input  logic                i_file_end,
    input  logic                i_q_full,
    output logic                o_push,
    output pnm_pkg::t_cmd       o_cmd,
    output logic [DIM_BITS-1:0] o_cmd_width,
    output logic [DIM_BITS-1:0] o_cmd_height
);
    import pnm_pkg::*;

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    localparam int CW = DIM_BITS + 2;  // sample count in a row, up to 3x width

    typedef enum logic [3:0] {
        PH_MAGIC, PH_TYPE, PH_GAP_FIRST, PH_GAP, PH_COMMENT,
        PH_NUMBER, PH_RASTER, PH_DONE, PH_DRAIN
    } t_phase;

    t_phase              r_phase,  n_phase;
    logic [1:0]          r_fmt,    n_fmt;
    logic [DIM_BITS-1:0] r_accum,  n_accum;
    logic [1:0]          r_field,  n_field;
    logic [DIM_BITS-1:0] r_width,  n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic [DIM_BITS-1:0] r_row,    n_row;
    logic [CW-1:0]       r_col,    n_col;
    logic [CW-1:0]       r_limit,  n_limit;

    logic                accept;
    logic                emit;
    logic                is_ws;
    logic                is_digit;
    logic [7:0]          digit_b;
    logic [7:0]          type_b;
    logic [DIM_BITS+3:0] acc_ext;
    logic [DIM_BITS+3:0] prod;
    logic [CW-1:0]       width_ext;
    logic [CW-1:0]       width3;
    logic [CW-1:0]       remaining;
    logic [3:0]          take;
    logic [CW-1:0]       col_next;
    logic [DIM_BITS:0]   row_next;
    logic [1:0]          last_field;
    t_cmd                cmd;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign is_ws    = (i_byte_in == CH_SP) || (i_byte_in == CH_TAB) ||
                      (i_byte_in == CH_CR) || (i_byte_in == CH_LF);
    assign is_digit = (i_byte_in >= CH_0) && (i_byte_in <= CH_9);
    assign digit_b  = i_byte_in - CH_0;
    assign type_b   = i_byte_in - CH_4;

    // accum * 10 + digit, with four guard bits for overflow detection
    assign acc_ext = {4'b0, r_accum};
    assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{DIM_BITS{1'b0}}, digit_b[3:0]};

    assign width_ext = {2'b0, r_width};
    assign width3    = (width_ext << 1) + width_ext;

    assign remaining = r_limit - r_col;
    assign take      = (r_fmt != FMT_PBM) ? 4'd1 :
                       (remaining >= CW'(8)) ? 4'd8 : remaining[3:0];
    assign col_next  = r_col + {{(CW-4){1'b0}}, take};
    assign row_next  = {1'b0, r_row} + {{DIM_BITS{1'b0}}, 1'b1};

    assign last_field = (r_fmt == FMT_PBM) ? 2'd1 : 2'd2;

    always_comb begin
        n_phase  = r_phase;
        n_fmt    = r_fmt;
        n_accum  = r_accum;
        n_field  = r_field;
        n_width  = r_width;
        n_height = r_height;
        n_row    = r_row;
        n_col    = r_col;
        n_limit  = r_limit;
        emit       = 1'b0;
        cmd.kind   = KIND_PIXEL;
        cmd.data   = 8'd0;
        cmd.fmt    = r_fmt;
        cmd.err    = ERR_NONE;
        cmd.cnt_m1 = 3'd0;
        cmd.pbm    = 1'b0;
        cmd.frame  = 1'b0;

        if (i_file_end) begin
            if (r_phase != PH_MAGIC && r_phase != PH_DONE && r_phase != PH_DRAIN) begin
                emit     = 1'b1;
                cmd.kind = KIND_ERROR;
                cmd.err  = ERR_TRUNC;
            end
            n_phase  = PH_MAGIC;
            n_fmt    = 2'd0;
            n_accum  = '0;
            n_field  = 2'd0;
            n_width  = '0;
            n_height = '0;
            n_row    = '0;
            n_col    = '0;
        end else begin
            unique case (r_phase)
                PH_MAGIC: begin
                    if (i_byte_in != CH_P) begin
                        emit = 1'b1; cmd.kind = KIND_ERROR; cmd.err = ERR_NO_P;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (i_byte_in < CH_4 || i_byte_in > CH_6) begin
                        emit = 1'b1; cmd.kind = KIND_ERROR; cmd.err = ERR_BAD_TYPE;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_fmt   = type_b[1:0];
                        n_phase = PH_GAP_FIRST;
                    end
                end
                PH_GAP_FIRST, PH_GAP: begin
                    if (is_ws) begin
                        n_phase = PH_GAP;
                    end else if (i_byte_in == CH_HASH) begin
                        n_phase = PH_COMMENT;
                    end else if (r_phase == PH_GAP_FIRST) begin
                        emit = 1'b1; cmd.kind = KIND_ERROR; cmd.err = ERR_NO_WS;
                        n_phase = PH_DRAIN;
                    end else if (!is_digit) begin
                        emit = 1'b1; cmd.kind = KIND_ERROR; cmd.err = ERR_BAD_NUM;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_accum = DIM_BITS'(digit_b[3:0]);
                        n_phase = PH_NUMBER;
                    end
                end
                PH_COMMENT: begin
                    if (i_byte_in == CH_CR || i_byte_in == CH_LF) n_phase = PH_GAP;
                end
                PH_NUMBER: begin
                    if (is_digit) begin
                        n_accum = prod[DIM_BITS-1:0];
                        if (prod[DIM_BITS+3:DIM_BITS] != 4'd0) begin
                            emit = 1'b1; cmd.kind = KIND_ERROR; cmd.err = ERR_BAD_NUM;
                            n_phase = PH_DRAIN;
                        end
                    end else begin
                        // number ends here
                        n_accum = '0;
                        if (r_field == 2'd0) n_width = r_accum;
                        else if (r_field == 2'd1) n_height = r_accum;
                        if (r_field >= last_field) begin
                            if (r_fmt != FMT_PBM && r_accum != DIM_BITS'(255)) begin
                                emit = 1'b1; cmd.kind = KIND_ERROR; cmd.err = ERR_MAXVAL;
                                n_phase = PH_DRAIN;
                            end else if (!is_ws) begin
                                emit = 1'b1; cmd.kind = KIND_ERROR; cmd.err = ERR_NO_WS;
                                n_phase = PH_DRAIN;
                            end else begin
                                emit     = 1'b1;
                                cmd.kind = KIND_HEADER;
                                n_row    = '0;
                                n_col    = '0;
                                n_limit  = (r_fmt == FMT_PPM) ? width3 : width_ext;
                                if (n_width == '0 || n_height == '0) begin
                                    cmd.frame = 1'b1;
                                    n_phase   = PH_DONE;
                                end else begin
                                    n_phase = PH_RASTER;
                                end
                            end
                        end else if (is_ws || i_byte_in == CH_HASH) begin
                            n_field = r_field + 2'd1;
                            n_phase = is_ws ? PH_GAP : PH_COMMENT;
                        end else begin
                            emit = 1'b1; cmd.kind = KIND_ERROR;
                            cmd.err = (r_fmt == FMT_PBM && r_field == 2'd0) ?
                                      ERR_NO_WS : ERR_BAD_NUM;
                            n_phase = PH_DRAIN;
                        end
                    end
                end
                PH_RASTER: begin
                    emit       = 1'b1;
                    cmd.kind   = KIND_PIXEL;
                    cmd.data   = i_byte_in;
                    cmd.pbm    = (r_fmt == FMT_PBM);
                    cmd.cnt_m1 = 3'(take - 4'd1);
                    n_col      = col_next;
                    if (col_next >= r_limit) begin
                        n_col = '0;
                        n_row = row_next[DIM_BITS-1:0];
                        if (row_next >= {1'b0, r_height}) begin
                            n_phase   = PH_DONE;
                            cmd.frame = 1'b1;
                        end
                    end
                end
                default: begin
                    // done or draining: bytes are dropped
                end
            endcase
        end
    end

    assign o_push       = accept && emit;
    assign o_cmd        = cmd;
    assign o_cmd_width  = i_file_end ? r_width  : n_width;
    assign o_cmd_height = i_file_end ? r_height : n_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_fmt    <= 2'd0;
            r_accum  <= '0;
            r_field  <= 2'd0;
            r_width  <= '0;
            r_height <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_limit  <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_fmt    <= n_fmt;
            r_accum  <= n_accum;
            r_field  <= n_field;
            r_width  <= n_width;
            r_height <= n_height;
            r_row    <= n_row;
            r_col    <= n_col;
            r_limit  <= n_limit;
        end
    end

endmodule

// ===== rtl/pnm_fifo.sv =====
// Small register queue between the parser and the result expander.
`timescale 1ns / 1ps
module pnm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ===== rtl/pnm_back.sv =====
// Result expander: plays each queued entry out as one or more result transactions.
`timescale 1ns / 1ps
module pnm_back #(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  pnm_pkg::t_cmd       i_q_cmd,
    input  logic [DIM_BITS-1:0] i_q_width,
    input  logic [DIM_BITS-1:0] i_q_height,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_out_kind,
    output logic [7:0]          o_pixel,
    output logic [1:0]          o_image_format,
    output logic [DIM_BITS-1:0] o_image_width,
    output logic [DIM_BITS-1:0] o_image_height,
    output logic [2:0]          o_error_code,
    output logic                o_last_in_run,
    output logic                o_frame_done
);
    import pnm_pkg::*;

    t_cmd                r_cur;
    logic [DIM_BITS-1:0] r_cur_w;
    logic [DIM_BITS-1:0] r_cur_h;
    logic                r_cur_valid;
    logic [2:0]          r_bit;
    logic                r_out_valid;
    logic [1:0]          r_kind;
    logic [7:0]          r_pixel;
    logic [1:0]          r_fmt;
    logic [DIM_BITS-1:0] r_w;
    logic [DIM_BITS-1:0] r_h;
    logic [2:0]          r_err;
    logic                r_last;
    logic                r_frame;

    logic out_free;
    logic cur_last;
    logic emit;

    assign out_free = !r_out_valid || i_out_ready;
    assign cur_last = (r_bit == r_cur.cnt_m1);
    assign emit     = out_free && r_cur_valid;
    assign o_pop    = !i_q_empty && (!r_cur_valid || (emit && cur_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_bit       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_bit       <= 3'd0;
            end else if (emit) begin
                if (cur_last) r_cur_valid <= 1'b0;
                else r_bit <= r_bit + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur   <= i_q_cmd;
            r_cur_w <= i_q_width;
            r_cur_h <= i_q_height;
        end
        if (emit) begin
            r_kind  <= r_cur.kind;
            // bitmap bytes go out MSB first
            r_pixel <= r_cur.pbm ? {7'b0, r_cur.data[3'd7 - r_bit]} : r_cur.data;
            r_fmt   <= r_cur.fmt;
            r_w     <= r_cur_w;
            r_h     <= r_cur_h;
            r_err   <= r_cur.err;
            r_last  <= cur_last;
            r_frame <= cur_last && r_cur.frame;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_kind;
    assign o_pixel        = r_pixel;
    assign o_image_format = r_fmt;
    assign o_image_width  = r_w;
    assign o_image_height = r_h;
    assign o_error_code   = r_err;
    assign o_last_in_run  = r_last;
    assign o_frame_done   = r_frame;

endmodule

// ===== rtl/pnm_raw_stream_decoder.sv =====
// Raw PNM (P4/P5/P6) byte-stream decoder, top level.
// A byte accepted by the parser is registered in the queue, then in the expander's
// current entry, then in the result port. Throughput: one byte per cycle for PGM/PPM
// while the queue has room and the sink is ready; a PBM byte yields up to 8 pixels.
// The parser keeps taking bytes while the queue has room, so header bytes and
// short bytes overlap with the expansion of earlier bitmap bytes.
// Reset (i_rst_n low, synchronous) empties the queue and returns to waiting for 'P'.
`timescale 1ns / 1ps
module pnm_raw_stream_decoder #(
    parameter int DIM_BITS   = 16,
    parameter int FIFO_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_byte_in,
    input  logic                i_file_end,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_out_kind,
    output logic [7:0]          o_pixel,
    output logic [1:0]          o_image_format,
    output logic [DIM_BITS-1:0] o_image_width,
    output logic [DIM_BITS-1:0] o_image_height,
    output logic [2:0]          o_error_code,
    output logic                o_last_in_run,
    output logic                o_frame_done
);
    import pnm_pkg::*;

    // queue entry: command plus the width/height snapshot at the time of the transaction
    localparam int QW = $bits(t_cmd) + 2 * DIM_BITS;

    logic                push;
    t_cmd                push_cmd;
    logic [DIM_BITS-1:0] push_w;
    logic [DIM_BITS-1:0] push_h;
    logic                q_full;
    logic                q_empty;
    logic                pop;
    logic [QW-1:0]       q_wdata;
    logic [QW-1:0]       q_rdata;
    t_cmd                q_cmd;
    logic [DIM_BITS-1:0] q_w;
    logic [DIM_BITS-1:0] q_h;

    // Front end: header parsing, raster bookkeeping; one byte per cycle unless q_full.
    pnm_front #(
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_byte_in    (i_byte_in),
        .i_file_end   (i_file_end),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_cmd_width  (push_w),
        .o_cmd_height (push_h)
    );

    assign q_wdata = {push_cmd, push_w, push_h};

    // Decoupling queue: lets the parser run ahead while bitmap bytes expand.
    pnm_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign q_cmd = t_cmd'(q_rdata[QW-1 -: $bits(t_cmd)]);
    assign q_w   = q_rdata[2*DIM_BITS-1:DIM_BITS];
    assign q_h   = q_rdata[DIM_BITS-1:0];

    // Back end: one result per cycle while the sink is ready, into a registered output.
    pnm_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_cmd        (q_cmd),
        .i_q_width      (q_w),
        .i_q_height     (q_h),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_kind     (o_out_kind),
        .o_pixel        (o_pixel),
        .o_image_format (o_image_format),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_error_code   (o_error_code),
        .o_last_in_run  (o_last_in_run),
        .o_frame_done   (o_frame_done)
    );

endmodule

// ===== tb/sv/tb_pnm_raw_stream_decoder.sv =====
// Self-checking testbench for the raw PNM stream decoder: directed table, random files, scoreboard.
`timescale 1ns / 1ps
module tb_pnm_raw_stream_decoder;
    import pnm_pkg::*;

    localparam int DIM_BITS = 16;
    localparam int unsigned DIM_MAX = (1 << DIM_BITS) - 1;

    // Ways a random file gets broken.
    localparam int FLAW_NONE     = 0;
    localparam int FLAW_MAXVAL   = 1;
    localparam int FLAW_OVERFLOW = 2;
    localparam int FLAW_SIGN     = 3;
    localparam int FLAW_CORRUPT  = 4;
    localparam int FLAW_CUT      = 5;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam int RANDOM_BYTES = 180;
    localparam int HOLD_AT      = 50;   // result index where the sink holds off
    localparam int HOLD_CYCLES  = 120;  // long enough to fill the queue and stall input
    localparam int DRAIN_CYCLES = 40;

    // Header parser phases of the scoreboard's own decoder.
    typedef enum logic [3:0] {
        ST_MAGIC, ST_TYPE, ST_GAP_FIRST, ST_GAP, ST_COMMENT,
        ST_NUMBER, ST_RASTER, ST_DONE, ST_DRAIN
    } parse_st_t;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          pixel;
        logic [1:0]          fmt;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic [2:0]          err;
        logic                last;
        logic                frame;
    } pnm_result_t;

    // One input transaction; 'typed' rows carry a hand-written kind/error/frame.
    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       typed;
        t_kind      kind;
        logic [2:0] err;
        logic       frame;
    } byte_txn_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [7:0]          i_byte_in;
    logic                i_file_end;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [1:0]          o_out_kind;
    logic [7:0]          o_pixel;
    logic [1:0]          o_image_format;
    logic [DIM_BITS-1:0] o_image_width;
    logic [DIM_BITS-1:0] o_image_height;
    logic [2:0]          o_error_code;
    logic                o_last_in_run;
    logic                o_frame_done;

    pnm_raw_stream_decoder #(
        .DIM_BITS(DIM_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_byte_in     (i_byte_in),
        .i_file_end    (i_file_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_kind    (o_out_kind),
        .o_pixel       (o_pixel),
        .o_image_format(o_image_format),
        .o_image_width (o_image_width),
        .o_image_height(o_image_height),
        .o_error_code  (o_error_code),
        .o_last_in_run (o_last_in_run),
        .o_frame_done  (o_frame_done)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Scoreboard decoder state.
    parse_st_t   parse_st;
    logic [1:0]  img_fmt;
    int unsigned num_acc;
    int unsigned num_field;
    int unsigned img_w;
    int unsigned img_h;
    int unsigned row_idx;
    int unsigned sample_idx;

    pnm_result_t pending_results[$];
    byte_txn_t   directed_rows[$];
    logic [7:0]  file_q[$];
    byte_txn_t   cur_txn;
    int          error_count = 0;
    bit          send_calm = 1'b0;

    function automatic bit is_space(input logic [7:0] b);
        return b == " " || b == "\t" || b == CH_CR || b == CH_LF;
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0: return " ";
            1: return "\t";
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic byte_txn_t mk_txn(input logic [7:0] b, input logic eof);
        byte_txn_t t;
        t.data  = b;
        t.eof   = eof;
        t.typed = 1'b0;
        t.kind  = KIND_PIXEL;
        t.err   = ERR_NONE;
        t.frame = 1'b0;
        return t;
    endfunction

    task automatic row(input logic [7:0] b, input logic eof);
        directed_rows.push_back(mk_txn(b, eof));
    endtask

    task automatic row_chk(input logic [7:0] b, input logic eof, input t_kind kind,
                           input logic [2:0] err, input logic frame);
        byte_txn_t t;
        t       = mk_txn(b, eof);
        t.typed = 1'b1;
        t.kind  = kind;
        t.err   = err;
        t.frame = frame;
        directed_rows.push_back(t);
    endtask

    task automatic clear_decoder();
        parse_st   = ST_MAGIC;
        img_fmt    = FMT_PBM;
        num_acc    = 0;
        num_field  = 0;
        img_w      = 0;
        img_h      = 0;
        row_idx    = 0;
        sample_idx = 0;
    endtask

    // Results always report the format and dimensions as parsed so far.
    task automatic emit(input t_kind kind, input logic [7:0] pix, input logic [2:0] code,
                        input logic frame);
        pnm_result_t r;
        r.kind   = kind;
        r.pixel  = pix;
        r.fmt    = img_fmt;
        r.width  = img_w[DIM_BITS-1:0];
        r.height = img_h[DIM_BITS-1:0];
        r.err    = code;
        r.last   = 1'b0;
        r.frame  = frame;
        pending_results.push_back(r);
    endtask

    task automatic raise_error(input logic [2:0] code);
        parse_st = ST_DRAIN;
        emit(KIND_ERROR, 8'h00, code, 1'b0);
    endtask

    // Works out every result one accepted byte (or end of file) causes.
    task automatic decode_byte(input logic [7:0] b, input logic eof);
        int unsigned n0;
        int unsigned val;
        int unsigned final_field;
        int unsigned limit;
        pnm_result_t r;
        n0 = pending_results.size();
        if (eof) begin
            // end of file mid-image is a truncation; idle, done and drain just reset
            if (parse_st != ST_MAGIC && parse_st != ST_DONE && parse_st != ST_DRAIN)
                emit(KIND_ERROR, 8'h00, ERR_TRUNC, 1'b0);
            clear_decoder();
        end else begin
            case (parse_st)
                ST_MAGIC: begin
                    if (b != "P") raise_error(ERR_NO_P);
                    else parse_st = ST_TYPE;
                end
                ST_TYPE: begin
                    if (b < "4" || b > "6") begin
                        raise_error(ERR_BAD_TYPE);
                    end else begin
                        img_fmt  = 2'(b - "4");
                        parse_st = ST_GAP_FIRST;
                    end
                end
                ST_GAP_FIRST, ST_GAP: begin
                    if (is_space(b)) parse_st = ST_GAP;
                    else if (b == "#") parse_st = ST_COMMENT;
                    else if (parse_st == ST_GAP_FIRST) raise_error(ERR_NO_WS);
                    else if (b < "0" || b > "9") raise_error(ERR_BAD_NUM);
                    else begin
                        num_acc  = 32'(b - "0");
                        parse_st = ST_NUMBER;
                    end
                end
                ST_COMMENT: begin
                    if (b == CH_CR || b == CH_LF) parse_st = ST_GAP;
                end
                ST_NUMBER: begin
                    if (b >= "0" && b <= "9") begin
                        num_acc = num_acc * 10 + 32'(b - "0");
                        if (num_acc > DIM_MAX) raise_error(ERR_BAD_NUM);
                    end else begin
                        // terminator of width, height or maxval
                        val         = num_acc;
                        final_field = (img_fmt == FMT_PBM) ? 1 : 2;
                        num_acc     = 0;
                        if (num_field == 0) img_w = val;
                        else if (num_field == 1) img_h = val;
                        if (num_field >= final_field) begin
                            if (img_fmt != FMT_PBM && val != 255) begin
                                raise_error(ERR_MAXVAL);
                            end else if (!is_space(b)) begin
                                raise_error(ERR_NO_WS);
                            end else begin
                                row_idx    = 0;
                                sample_idx = 0;
                                if (img_w == 0 || img_h == 0) begin
                                    parse_st = ST_DONE;
                                    emit(KIND_HEADER, 8'h00, ERR_NONE, 1'b1);
                                end else begin
                                    parse_st = ST_RASTER;
                                    emit(KIND_HEADER, 8'h00, ERR_NONE, 1'b0);
                                end
                            end
                        end else if (is_space(b) || b == "#") begin
                            num_field++;
                            parse_st = is_space(b) ? ST_GAP : ST_COMMENT;
                        end else begin
                            raise_error((img_fmt == FMT_PBM && num_field == 0) ?
                                        ERR_NO_WS : ERR_BAD_NUM);
                        end
                    end
                end
                ST_RASTER: begin
                    limit = (img_fmt == FMT_PPM) ? img_w * 3 : img_w;
                    if (img_fmt == FMT_PBM) begin
                        // MSB first; bits past the row width are padding
                        for (int k = 7; k >= 0; k--) begin
                            if (sample_idx < limit) begin
                                emit(KIND_PIXEL, {7'd0, b[k]}, ERR_NONE, 1'b0);
                                sample_idx++;
                            end
                        end
                    end else begin
                        emit(KIND_PIXEL, b, ERR_NONE, 1'b0);
                        sample_idx++;
                    end
                    if (sample_idx >= limit) begin
                        sample_idx = 0;
                        row_idx++;
                        if (row_idx >= img_h) begin
                            parse_st = ST_DONE;
                            if (pending_results.size() > n0) begin
                                r       = pending_results.pop_back();
                                r.frame = 1'b1;
                                pending_results.push_back(r);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (pending_results.size() > n0) begin
            r      = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    // Checks the result transaction first, then predicts from the input transaction,
    // both on the same edge, so the scoreboard order never depends on process order.
    always @(posedge i_clk) begin : scoreboard
        pnm_result_t want;
        int unsigned n0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: out_kind %0d with nothing pending", o_out_kind);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_kind !== want.kind) begin
                        $error("out_kind: expected %0d, got %0d", want.kind, o_out_kind);
                        error_count++;
                    end
                    if (o_pixel !== want.pixel) begin
                        $error("pixel: expected %0d, got %0d", want.pixel, o_pixel);
                        error_count++;
                    end
                    if (o_image_format !== want.fmt) begin
                        $error("image_format: expected %0d, got %0d", want.fmt, o_image_format);
                        error_count++;
                    end
                    if (o_image_width !== want.width) begin
                        $error("image_width: expected %0d, got %0d", want.width, o_image_width);
                        error_count++;
                    end
                    if (o_image_height !== want.height) begin
                        $error("image_height: expected %0d, got %0d", want.height,
                               o_image_height);
                        error_count++;
                    end
                    if (o_error_code !== want.err) begin
                        $error("error_code: expected %0d, got %0d", want.err, o_error_code);
                        error_count++;
                    end
                    if (o_last_in_run !== want.last) begin
                        $error("last_in_run: expected %0d, got %0d", want.last, o_last_in_run);
                        error_count++;
                    end
                    if (o_frame_done !== want.frame) begin
                        $error("frame_done: expected %0d, got %0d", want.frame, o_frame_done);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                n0 = pending_results.size();
                decode_byte(i_byte_in, i_file_end);
                // hand-written rows: kind, error code and frame flag come from the table
                if (cur_txn.typed) begin
                    if (pending_results.size() == n0)
                        emit(cur_txn.kind, 8'h00, cur_txn.err, cur_txn.frame);
                    want       = pending_results.pop_back();
                    want.kind  = cur_txn.kind;
                    want.err   = cur_txn.err;
                    want.frame = cur_txn.frame;
                    want.last  = 1'b1;
                    pending_results.push_back(want);
                end
            end
        end
    end

    // Offers one byte transaction after a random gap; returns at the falling edge
    // after it was taken. Valid stays high back to back when the gap is zero.
    task automatic put_byte(input byte_txn_t t);
        int gap;
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= t.data;
        i_file_end <= t.eof;
        cur_txn    <= t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_num(input int unsigned v);
        logic [7:0] digits[$];
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) file_q.push_back("0");
        do begin
            digits.push_front(8'("0" + v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) file_q.push_back(digits[i]);
    endtask

    // Header separator: whitespace, sometimes a comment line in front of it.
    task automatic add_gap();
        logic [7:0] c;
        bit         noted;
        noted = ($urandom_range(0, 3) == 0);
        if (noted) begin
            file_q.push_back("#");
            repeat ($urandom_range(0, 4)) begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
                file_q.push_back(c);
            end
            file_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
        repeat ($urandom_range(noted ? 0 : 1, 2)) file_q.push_back(pick_space());
    endtask

    // Result sink: random back-pressure per result, one long hold-off to fill the block.
    initial begin : result_sink
        int  wait_cycles;
        int  taken;
        bit  calm;
        i_out_ready = 1'b0;
        taken = 0;
        calm  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            wait_cycles = calm ? 0 : $urandom_range(0, 12);
            if (taken == HOLD_AT) wait_cycles = HOLD_CYCLES;
            if (wait_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int          sent;
        int          fmt_pick;
        int unsigned w;
        int unsigned h;
        int unsigned maxv;
        int          flaw;
        int unsigned row_bytes;
        int unsigned raw;
        int unsigned cut;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_byte_in  = 8'h00;
        i_file_end = 1'b0;
        cur_txn    = mk_txn(8'h00, 1'b0);
        clear_decoder();

        // Directed table: header errors, zero-size image, ignored bytes, truncation.
        row_chk("X", 0, KIND_ERROR, ERR_NO_P, 0);         // wrong magic
        row(8'h00, 1);                                    // end of file while draining
        row(8'hFF, 1);                                    // end of file while idle
        row("P", 0);
        row_chk("3", 0, KIND_ERROR, ERR_BAD_TYPE, 0);     // type just below '4'
        row(8'h00, 1);
        row("P", 0);
        row("5", 0);
        row_chk("A", 0, KIND_ERROR, ERR_NO_WS, 0);        // type not followed by a gap
        row(8'h00, 1);
        row("P", 0);
        row("5", 0);
        row("#", 0);
        row(CH_LF, 0);
        row_chk("-", 0, KIND_ERROR, ERR_BAD_NUM, 0);      // sign where width starts
        row(8'h00, 1);
        row("P", 0);
        row("4", 0);
        row(" ", 0);
        row("0", 0);
        row("\t", 0);
        row("0", 0);
        row_chk(CH_LF, 0, KIND_HEADER, ERR_NONE, 1);      // 0x0 bitmap, frame done at once
        row(8'hFF, 0);                                    // after the image: ignored
        row(8'h00, 1);
        row("P", 0);
        row("6", 0);
        row_chk(8'h00, 1, KIND_ERROR, ERR_TRUNC, 0);      // file ends inside the header

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) put_byte(directed_rows[i]);

        // Random files: mostly well formed with random dimensions, comments and raster,
        // the rest broken in one of several ways.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            fmt_pick = $urandom_range(0, 2);
            w = $urandom_range(1, (fmt_pick == FMT_PBM) ? 12 : 4);
            h = $urandom_range(1, 3);
            case ($urandom_range(0, 15))
                0: w = 0;
                1: h = 0;
                2: w = DIM_MAX;
                3: h = DIM_MAX;
                default: ;
            endcase
            maxv = 255;
            flaw = ($urandom_range(0, 9) < 3) ? $urandom_range(FLAW_MAXVAL, FLAW_CUT) : FLAW_NONE;
            if (flaw == FLAW_MAXVAL)
                maxv = $urandom_range(0, 1) ? $urandom_range(0, 254) : $urandom_range(256, 70000);
            if (flaw == FLAW_OVERFLOW) w = $urandom_range(DIM_MAX + 1, 999999);

            file_q.delete();
            file_q.push_back("P");
            file_q.push_back(8'("4" + fmt_pick));
            add_gap();
            if (flaw == FLAW_SIGN) file_q.push_back($urandom_range(0, 1) ? "-" : "+");
            add_num(w);
            add_gap();
            add_num(h);
            if (fmt_pick != FMT_PBM) begin
                add_gap();
                add_num(maxv);
            end
            file_q.push_back(pick_space());

            row_bytes = (fmt_pick == FMT_PBM) ? (w + 7) / 8 : ((fmt_pick == FMT_PPM) ? 3 * w : w);
            // huge images only get a few raster bytes, so the file ends truncated
            if (w > 64 || h > 64) raw = $urandom_range(1, 8);
            else raw = row_bytes * h + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            repeat (raw) file_q.push_back(8'($urandom_range(0, 255)));

            if (flaw == FLAW_CORRUPT)
                file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
            if (flaw == FLAW_CUT) begin
                cut = $urandom_range(1, file_q.size() - 1);
                while (file_q.size() > cut) file_q.delete(file_q.size() - 1);
            end

            foreach (file_q[i]) put_byte(mk_txn(file_q[i], 1'b0));
            put_byte(mk_txn(8'($urandom_range(0, 255)), 1'b1));
            sent += file_q.size() + 1;
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== pnm_raw_stream_decoder.f =====
rtl/pnm_pkg.sv
rtl/pnm_front.sv
rtl/pnm_fifo.sv
rtl/pnm_back.sv
rtl/pnm_raw_stream_decoder.sv
tb/sv/tb_pnm_raw_stream_decoder.sv
